// ===== sv/dq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants and types for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // movement applied to every cell of the chain in the same cycle
    typedef struct packed {
        logic shift_right;  // push front: each cell takes its left neighbour
        logic shift_left;   // pop front: each cell takes its right neighbour
    } cell_ctl_t;

    // decoded command and its outcome
    typedef struct packed {
        logic               load_back;   // push back into slot at the count
        logic               take_front;  // word leaves from the first cell
        logic               take_back;   // word leaves from the cell below the count
        logic [1:0]         status;
        logic [COUNT_W-1:0] count_next;
    } op_t;

endpackage

// ===== sv/double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words built as a chain of word cells.
// ----------------------------------------------------------------------------
// Takes one command per clock and returns one result per command, in the
// cycle after the transfer, through an output register; a new command is taken
// while that result waits as long as the result is taken in the same cycle.
// The front word always sits in the first cell: a push or pop at the front
// shifts the whole chain one cell at once, a push at the back loads the cell
// at the current count, and a pop at the back reads the cell below it. Pops
// on an empty queue report underflow and pushes on a full one (16 words)
// report overflow; neither changes the contents. No clearing pass after reset.
module double_ended_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_cmd,
    input  logic signed [31:0]               s_push_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [31:0]               m_popped_value,
    output logic [1:0]                       m_status,
    output logic [4:0]                       m_element_count
);

    logic                              accept;
    dq_pkg::op_t                       op;
    dq_pkg::cell_ctl_t                 cell_ctl;
    logic [dq_pkg::COUNT_W-1:0]        count;
    logic signed [dq_pkg::WORD_W-1:0]  cell_word [dq_pkg::CAPACITY];
    logic [dq_pkg::SLOT_W-1:0]         back_slot;
    logic signed [dq_pkg::WORD_W-1:0]  popped;

    logic                              m_valid_reg;
    logic signed [dq_pkg::WORD_W-1:0]  popped_reg;
    logic [1:0]                        status_reg;
    logic [4:0]                        count_out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .cmd      (s_cmd),
        .op       (op),
        .cell_ctl (cell_ctl),
        .count    (count)
    );

    for (genvar i = 0; i < dq_pkg::CAPACITY; i++) begin : g_cell
        logic signed [dq_pkg::WORD_W-1:0] left_word;
        logic signed [dq_pkg::WORD_W-1:0] right_word;

        if (i == 0) begin : g_head
            assign left_word = s_push_value;
        end else begin : g_mid
            assign left_word = cell_word[i-1];
        end
        if (i == dq_pkg::CAPACITY - 1) begin : g_tail
            assign right_word = '0;
        end else begin : g_body
            assign right_word = cell_word[i+1];
        end

        dq_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .load       (op.load_back && (count == dq_pkg::COUNT_W'(i))),
            .left_word  (left_word),
            .right_word (right_word),
            .push_word  (s_push_value),
            .word       (cell_word[i])
        );
    end

    // back word lives in the cell just below the count
    assign back_slot = dq_pkg::SLOT_W'(count - 1'b1);

    always_comb begin
        popped = '0;
        if (op.take_front) begin
            popped = cell_word[0];
        end else if (op.take_back) begin
            popped = cell_word[back_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            popped_reg    <= popped;
            status_reg    <= op.status;
            count_out_reg <= 5'(op.count_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_popped_value  = popped_reg;
    assign m_status        = status_reg;
    assign m_element_count = count_out_reg;

endmodule

// ===== sv/dq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell
// One word of the queue; loads from its neighbours or the pushed word.
// ----------------------------------------------------------------------------
module dq_cell (
    input  logic                             aclk,
    input  dq_pkg::cell_ctl_t                ctl,
    input  logic                             load,
    input  logic signed [dq_pkg::WORD_W-1:0] left_word,
    input  logic signed [dq_pkg::WORD_W-1:0] right_word,
    input  logic signed [dq_pkg::WORD_W-1:0] push_word,
    output logic signed [dq_pkg::WORD_W-1:0] word
);

    logic signed [dq_pkg::WORD_W-1:0] word_reg;
    logic signed [dq_pkg::WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (ctl.shift_right) begin
            word_next = left_word;
        end else if (ctl.shift_left) begin
            word_next = right_word;
        end else if (load) begin
            word_next = push_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== sv/dq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Command decode and element count for the cell chain.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [1:0]                        cmd,
    output dq_pkg::op_t                       op,
    output dq_pkg::cell_ctl_t                 cell_ctl,
    output logic [dq_pkg::COUNT_W-1:0]        count
);

    logic [dq_pkg::COUNT_W-1:0] count_reg;
    logic                       full;
    logic                       empty;

    assign full  = (count_reg == dq_pkg::COUNT_W'(dq_pkg::CAPACITY));
    assign empty = (count_reg == '0);

    always_comb begin
        op            = '0;
        op.status     = dq_pkg::ST_OK;
        op.count_next = count_reg;
        cell_ctl      = '0;
        case (cmd)
            dq_pkg::CMD_PUSH_FRONT: begin
                if (full) begin
                    op.status = dq_pkg::ST_OVERFLOW;
                end else begin
                    cell_ctl.shift_right = 1'b1;
                    op.count_next        = count_reg + 1'b1;
                end
            end
            dq_pkg::CMD_PUSH_BACK: begin
                if (full) begin
                    op.status = dq_pkg::ST_OVERFLOW;
                end else begin
                    op.load_back  = 1'b1;
                    op.count_next = count_reg + 1'b1;
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (empty) begin
                    op.status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    cell_ctl.shift_left = 1'b1;
                    op.take_front       = 1'b1;
                    op.count_next       = count_reg - 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                if (empty) begin
                    op.status = dq_pkg::ST_UNDERFLOW;
                end else begin
                    op.take_back  = 1'b1;
                    op.count_next = count_reg - 1'b1;
                end
            end
            default: begin
                op.status = dq_pkg::ST_OK;
            end
        endcase
        // chain only moves on a transfer
        if (!accept) begin
            cell_ctl     = '0;
            op.load_back = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= op.count_next;
        end
    end

    assign count = count_reg;

endmodule
